// ===== sv/epp_pkg.sv =====
// Shared types, constants and helper functions of the ego-motion position predictor.
// Depends on nothing; every other file imports it.
package epp_pkg;

  localparam int FRACTION_BITS     = 16;
  localparam int CORDIC_ITERATIONS = 16;

  // CORDIC datapath width: two integer bits of headroom above the angle range.
  localparam int CW        = FRACTION_BITS + 4;
  // Conditional subtract steps of the angle reduction (quotient below 2^18).
  localparam int RED_STEPS = 18;
  localparam int PROD_W    = 53;
  localparam int RED_W     = 53;
  localparam int DIFF_W    = 33;
  localparam int BASE_W    = 37;
  localparam int MUL_W     = DIFF_W + CW;
  localparam int ROT_W     = MUL_W + 1 - FRACTION_BITS;
  localparam int SUM_W     = ROT_W + 1;

  localparam longint PI_Q60   = 64'sh3243F6A8885A308D;
  localparam longint GAIN_Q32 = 64'sd2608131496;
  localparam logic [RED_W-1:0] TWO_PI_Q32 = 53'h6487ED511;

  // Round to nearest with ties upward, on elaboration-time constants.
  function automatic longint rnd_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Unsigned quotient by shift and conditional subtract, for elaboration-time constants.
  function automatic longint udiv_c(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return longint'(q);
  endfunction

  localparam logic signed [CW-1:0] PI_F      = CW'(rnd_shr(PI_Q60, 60 - FRACTION_BITS));
  localparam logic signed [CW-1:0] TWO_PI_F  = CW'(rnd_shr(2 * PI_Q60, 60 - FRACTION_BITS));
  localparam logic signed [CW-1:0] HALF_PI_F = CW'(rnd_shr(PI_Q60, 61 - FRACTION_BITS));
  localparam logic signed [CW-1:0] GAIN_F    = CW'(rnd_shr(GAIN_Q32, 32 - FRACTION_BITS));

  // atan(2^-i) from its series in Q.62, rounded to the CORDIC fraction.
  function automatic logic signed [CW-1:0] atan_f(int i);
    longint sum;
    longint term;
    int     e;
    sum = 0;
    if (i == 0) begin
      sum = PI_Q60;
    end else begin
      for (int k = 0; k < 64; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e >= 0) begin
          term = udiv_c(64'd1 << e, 64'(2 * k + 1));
          if ((k & 1) == 1) sum = sum - term;
          else sum = sum + term;
        end
      end
    end
    return CW'(rnd_shr(sum, 62 - FRACTION_BITS));
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [SUM_W-1:0] v);
    if ((&v[SUM_W-1:31]) || !(|v[SUM_W-1:31])) return v[31:0];
    else if (v[SUM_W-1]) return 32'sh8000_0000;
    else return 32'sh7FFF_FFFF;
  endfunction

  // Values that ride alongside the angle through the pipeline.
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [BASE_W-1:0] bx;
    logic signed [BASE_W-1:0] by;
    logic signed [31:0]       pz;
  } side_t;

endpackage

// ===== sv/ego_motion_position_predict_unit.sv =====
// Top level of the ego-motion position predictor: predicted target position from host motion.
// Depends on epp_pkg, epp_front, epp_reduce, epp_cordic and epp_rotate.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-----------------------------------
//   input    | in        | in_valid_i / in_stall_o   | target, host, velocity, yaw, dt
//   output   | out       | out_valid_o / out_stall_i | predicted_x/y/z
//
// One item per cycle while the output is not stalled, through 2 front stages, 18 reduction
// steps and a fold, 16 CORDIC iterations and a sign fix, and 3 rotation stages.
// Reset clears only the valid bits of the stages.
// A stalled result at the output freezes the whole pipeline; nothing is lost or repeated.
module ego_motion_position_predict_unit import epp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  input  logic signed [31:0] host_x_i,
  input  logic signed [31:0] host_y_i,
  input  logic signed [31:0] host_z_i,
  input  logic signed [31:0] host_vx_i,
  input  logic signed [31:0] host_vy_i,
  input  logic signed [31:0] host_vz_i,
  input  logic signed [31:0] yaw_rate_i,
  input  logic        [19:0] time_step_i,
  input  logic               host_valid_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] predicted_x_o,
  output logic signed [31:0] predicted_y_o,
  output logic signed [31:0] predicted_z_o
);

  logic                 en;
  logic                 f_vld, r_vld, c_vld;
  logic [RED_W-1:0]     f_ang;
  side_t                f_side, r_side, c_side;
  logic signed [CW-1:0] r_z, c_cos, c_sin;
  logic                 r_neg;
  logic                 host_z_unused;

  // The host z position cancels out of the z prediction.
  assign host_z_unused = ^host_z_i;

  assign en         = !(out_valid_o && out_stall_i) || (host_z_unused && 1'b0);
  assign in_stall_o = !en;

  epp_front u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i),
    .target_x_i, .target_y_i, .target_z_i, .host_x_i, .host_y_i,
    .host_vx_i, .host_vy_i, .host_vz_i, .yaw_rate_i, .time_step_i, .host_valid_i,
    .vld_o(f_vld), .ang_o(f_ang), .side_o(f_side)
  );

  epp_reduce u_reduce (
    .clk_i, .rst_ni, .en_i(en), .vld_i(f_vld), .ang_i(f_ang), .side_i(f_side),
    .vld_o(r_vld), .z_o(r_z), .neg_o(r_neg), .side_o(r_side)
  );

  epp_cordic u_cordic (
    .clk_i, .rst_ni, .en_i(en), .vld_i(r_vld), .z_i(r_z), .neg_i(r_neg), .side_i(r_side),
    .vld_o(c_vld), .cos_o(c_cos), .sin_o(c_sin), .side_o(c_side)
  );

  epp_rotate u_rotate (
    .clk_i, .rst_ni, .en_i(en), .vld_i(c_vld), .cos_i(c_cos), .sin_i(c_sin),
    .side_i(c_side), .vld_o(out_valid_o),
    .predicted_x_o, .predicted_y_o, .predicted_z_o
  );

endmodule

// ===== sv/epp_front.sv =====
// Front end: angle and displacement products, offsets and base positions.
// Depends on epp_pkg.
module epp_front import epp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  input  logic signed [31:0] host_x_i,
  input  logic signed [31:0] host_y_i,
  input  logic signed [31:0] host_vx_i,
  input  logic signed [31:0] host_vy_i,
  input  logic signed [31:0] host_vz_i,
  input  logic signed [31:0] yaw_rate_i,
  input  logic        [19:0] time_step_i,
  input  logic               host_valid_i,
  output logic               vld_o,
  output logic [RED_W-1:0]   ang_o,
  output side_t              side_o
);

  localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << 15;

  logic                      vld1_q, vld2_q, hv1_q;
  logic signed [PROD_W-1:0]  ang1_q, pvx1_q, pvy1_q, pvz1_q;
  logic signed [DIFF_W-1:0]  dx1_q, dy1_q;
  logic signed [31:0]        tx1_q, ty1_q, tz1_q, hx1_q, hy1_q;
  logic signed [PROD_W-1:0]  rvx, rvy, rvz;
  logic signed [SUM_W-1:0]   zsum;
  logic [RED_W-1:0]          ang2_d, ang2_q;
  side_t                     side2_d, side2_q;
  logic signed [PROD_W-1:0]  dt_s;

  assign dt_s = PROD_W'($signed({1'b0, time_step_i}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hv1_q  <= host_valid_i;
      ang1_q <= PROD_W'(yaw_rate_i) * dt_s;
      pvx1_q <= PROD_W'(host_vx_i) * dt_s;
      pvy1_q <= PROD_W'(host_vy_i) * dt_s;
      pvz1_q <= PROD_W'(host_vz_i) * dt_s;
      // Pass-through items carry no offset, so the rotation adds nothing.
      dx1_q  <= host_valid_i ? DIFF_W'(target_x_i) - DIFF_W'(host_x_i) : '0;
      dy1_q  <= host_valid_i ? DIFF_W'(target_y_i) - DIFF_W'(host_y_i) : '0;
      tx1_q  <= target_x_i;
      ty1_q  <= target_y_i;
      tz1_q  <= target_z_i;
      hx1_q  <= host_x_i;
      hy1_q  <= host_y_i;
    end
  end

  always_comb begin
    rvx  = (pvx1_q + HALF_LSB) >>> 16;
    rvy  = (pvy1_q + HALF_LSB) >>> 16;
    rvz  = (pvz1_q + HALF_LSB) >>> 16;
    zsum = SUM_W'(tz1_q) + SUM_W'(rvz);
    side2_d.dx = dx1_q;
    side2_d.dy = dy1_q;
    side2_d.bx = hv1_q ? BASE_W'(hx1_q) + BASE_W'(rvx) : BASE_W'(tx1_q);
    side2_d.by = hv1_q ? BASE_W'(hy1_q) + BASE_W'(rvy) : BASE_W'(ty1_q);
    side2_d.pz = hv1_q ? sat32(zsum) : tz1_q;
    // Lift negative angles by a multiple of two pi so the reduction sees a positive value.
    ang2_d = ang1_q[PROD_W-1] ? RED_W'(ang1_q) + (TWO_PI_Q32 << (RED_STEPS - 1))
                              : RED_W'(ang1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang2_q  <= ang2_d;
      side2_q <= side2_d;
    end
  end

  assign vld_o  = vld2_q;
  assign ang_o  = ang2_q;
  assign side_o = side2_q;

`ifndef SYNTHESIS
  a_pass_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && vld1_q && !hv1_q) |=> (side2_q.bx == BASE_W'($past(tx1_q))
                                    && side2_q.dx == '0))
    else $error("pass-through item picked up an offset");
`endif

endmodule

// ===== sv/epp_reduce.sv =====
// Angle reduction modulo two pi by restoring subtraction, then rounding and quadrant fold.
// Depends on epp_pkg.
module epp_reduce import epp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [RED_W-1:0]      ang_i,
  input  side_t                 side_i,
  output logic                  vld_o,
  output logic signed [CW-1:0]  z_o,
  output logic                  neg_o,
  output side_t                 side_o
);

  localparam logic [35:0] ZHALF = 36'(1) << (31 - FRACTION_BITS);

  logic             vld_st  [RED_STEPS+1];
  logic [RED_W-1:0] v_st    [RED_STEPS+1];
  side_t            side_st [RED_STEPS+1];

  assign vld_st[0]  = vld_i;
  assign v_st[0]    = ang_i;
  assign side_st[0] = side_i;

  for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
    localparam logic [RED_W-1:0] SUB = TWO_PI_Q32 << (RED_STEPS - 1 - j);
    logic             vld_q;
    logic [RED_W-1:0] v_q;
    side_t            side_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q <= 1'b0;
      else if (en_i) vld_q <= vld_st[j];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q    <= (v_st[j] >= SUB) ? v_st[j] - SUB : v_st[j];
        side_q <= side_st[j];
      end
    end

    assign vld_st[j+1]  = vld_q;
    assign v_st[j+1]    = v_q;
    assign side_st[j+1] = side_q;
  end

  logic [35:0]           zr;
  logic signed [CW-1:0]  z0, z1, z_d, z_q;
  logic                  neg_d, neg_q, fvld_q;
  side_t                 fside_q;

  always_comb begin
    zr    = (36'(v_st[RED_STEPS][34:0]) + ZHALF) >> (32 - FRACTION_BITS);
    z0    = signed'(CW'(zr));
    z1    = (z0 > PI_F) ? z0 - TWO_PI_F : z0;
    z_d   = z1;
    neg_d = 1'b0;
    // Outside the right half plane, rotate by pi and negate sine and cosine later.
    if (z1 > HALF_PI_F) begin
      z_d   = z1 - PI_F;
      neg_d = 1'b1;
    end else if (z1 < -HALF_PI_F) begin
      z_d   = z1 + PI_F;
      neg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fvld_q <= 1'b0;
    else if (en_i) fvld_q <= vld_st[RED_STEPS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q     <= z_d;
      neg_q   <= neg_d;
      fside_q <= side_st[RED_STEPS];
    end
  end

  assign vld_o  = fvld_q;
  assign z_o    = z_q;
  assign neg_o  = neg_q;
  assign side_o = fside_q;

`ifndef SYNTHESIS
  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_st[RED_STEPS] |-> (v_st[RED_STEPS] < TWO_PI_Q32))
    else $error("angle left the reduction at or above two pi");

  a_folded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fvld_q |-> (z_q <= HALF_PI_F && z_q >= -HALF_PI_F))
    else $error("folded angle outside plus or minus pi/2");
`endif

endmodule

// ===== sv/epp_cordic.sv =====
// Unrolled rotation-mode CORDIC, one iteration per register stage, plus the quadrant sign fix.
// Depends on epp_pkg.
module epp_cordic import epp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic signed [CW-1:0]  z_i,
  input  logic                  neg_i,
  input  side_t                 side_i,
  output logic                  vld_o,
  output logic signed [CW-1:0]  cos_o,
  output logic signed [CW-1:0]  sin_o,
  output side_t                 side_o
);

  logic                 vld_st  [CORDIC_ITERATIONS+1];
  logic signed [CW-1:0] x_st    [CORDIC_ITERATIONS+1];
  logic signed [CW-1:0] y_st    [CORDIC_ITERATIONS+1];
  logic signed [CW-1:0] z_st    [CORDIC_ITERATIONS+1];
  logic                 neg_st  [CORDIC_ITERATIONS+1];
  side_t                side_st [CORDIC_ITERATIONS+1];

  assign vld_st[0]  = vld_i;
  assign x_st[0]    = GAIN_F;
  assign y_st[0]    = '0;
  assign z_st[0]    = z_i;
  assign neg_st[0]  = neg_i;
  assign side_st[0] = side_i;

  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_iter
    localparam logic signed [CW-1:0] ANG = atan_f(i);
    logic                 vld_q, neg_q;
    logic signed [CW-1:0] x_q, y_q, z_q, xs, ys;
    side_t                side_q;

    assign xs = x_st[i] >>> i;
    assign ys = y_st[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q <= 1'b0;
      else if (en_i) vld_q <= vld_st[i];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_st[i][CW-1]) begin
          x_q <= x_st[i] - ys;
          y_q <= y_st[i] + xs;
          z_q <= z_st[i] - ANG;
        end else begin
          x_q <= x_st[i] + ys;
          y_q <= y_st[i] - xs;
          z_q <= z_st[i] + ANG;
        end
        neg_q  <= neg_st[i];
        side_q <= side_st[i];
      end
    end

    assign vld_st[i+1]  = vld_q;
    assign x_st[i+1]    = x_q;
    assign y_st[i+1]    = y_q;
    assign z_st[i+1]    = z_q;
    assign neg_st[i+1]  = neg_q;
    assign side_st[i+1] = side_q;
  end

  logic                 ovld_q;
  logic signed [CW-1:0] cos_q, sin_q;
  side_t                oside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovld_q <= 1'b0;
    else if (en_i) ovld_q <= vld_st[CORDIC_ITERATIONS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q   <= neg_st[CORDIC_ITERATIONS] ? -x_st[CORDIC_ITERATIONS] : x_st[CORDIC_ITERATIONS];
      sin_q   <= neg_st[CORDIC_ITERATIONS] ? -y_st[CORDIC_ITERATIONS] : y_st[CORDIC_ITERATIONS];
      oside_q <= side_st[CORDIC_ITERATIONS];
    end
  end

  assign vld_o  = ovld_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;
  assign side_o = oside_q;

endmodule

// ===== sv/epp_rotate.sv =====
// Offset rotation: four products, rounding, and the saturated sums that form the result.
// Depends on epp_pkg.
module epp_rotate import epp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic signed [CW-1:0]  cos_i,
  input  logic signed [CW-1:0]  sin_i,
  input  side_t                 side_i,
  output logic                  vld_o,
  output logic signed [31:0]    predicted_x_o,
  output logic signed [31:0]    predicted_y_o,
  output logic signed [31:0]    predicted_z_o
);

  localparam logic signed [MUL_W:0] HALF_F = (MUL_W+1)'(1) << (FRACTION_BITS - 1);

  logic                     vm_q, vr_q, vs_q;
  logic signed [MUL_W-1:0]  pxc_q, pys_q, pxs_q, pyc_q;
  logic signed [MUL_W:0]    rx_full, ry_full;
  logic signed [ROT_W-1:0]  rx_q, ry_q;
  logic signed [BASE_W-1:0] bxm_q, bym_q, bxr_q, byr_q;
  logic signed [31:0]       pzm_q, pzr_q;
  logic signed [SUM_W-1:0]  sx, sy;
  logic signed [31:0]       px_q, py_q, pz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      vr_q <= 1'b0;
      vs_q <= 1'b0;
    end else if (en_i) begin
      vm_q <= vld_i;
      vr_q <= vm_q;
      vs_q <= vr_q;
    end
  end

  always_comb begin
    rx_full = ((MUL_W+1)'(pxc_q) - (MUL_W+1)'(pys_q) + HALF_F) >>> FRACTION_BITS;
    ry_full = ((MUL_W+1)'(pxs_q) + (MUL_W+1)'(pyc_q) + HALF_F) >>> FRACTION_BITS;
    sx      = SUM_W'(bxr_q) + SUM_W'(rx_q);
    sy      = SUM_W'(byr_q) + SUM_W'(ry_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxc_q <= MUL_W'(side_i.dx) * MUL_W'(cos_i);
      pys_q <= MUL_W'(side_i.dy) * MUL_W'(sin_i);
      pxs_q <= MUL_W'(side_i.dx) * MUL_W'(sin_i);
      pyc_q <= MUL_W'(side_i.dy) * MUL_W'(cos_i);
      bxm_q <= side_i.bx;
      bym_q <= side_i.by;
      pzm_q <= side_i.pz;

      rx_q  <= ROT_W'(rx_full);
      ry_q  <= ROT_W'(ry_full);
      bxr_q <= bxm_q;
      byr_q <= bym_q;
      pzr_q <= pzm_q;

      px_q  <= sat32(sx);
      py_q  <= sat32(sy);
      pz_q  <= pzr_q;
    end
  end

  assign vld_o         = vs_q;
  assign predicted_x_o = px_q;
  assign predicted_y_o = py_q;
  assign predicted_z_o = pz_q;

endmodule
